>>> sv/ffpa_pkg.sv
// Shared types, constants and controller/datapath command and status structs.
package ffpa_pkg;

    localparam int MAX_POOL_BYTES_DEF = 16384;
    localparam int HEADER_BYTES_DEF   = 16;
    localparam int GRANULE_BYTES_DEF  = 8;

    localparam int SIZE_W  = 15;
    localparam int CNT_W   = 11;
    localparam int OFF_W   = 15;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;

    localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(16384);

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd2;

    localparam logic HDR_FREE = 1'b0;
    localparam logic HDR_USED = 1'b1;

    typedef enum logic [2:0] {
        RD_NONE, RD_ZERO, RD_LINK, RD_PREV, RD_NEXT
    } t_rd_sel;

    typedef enum logic [3:0] {
        WR_NONE, WR_INIT, WR_SPLIT_NEW, WR_SPLIT_CUR, WR_FIX_PREV_NB,
        WR_FIX_PREV_CUR, WR_SET_USED, WR_CLR_USED, WR_MERGE_BACK, WR_MERGE_FWD
    } t_wr_op;

    typedef enum logic [1:0] {
        CNT_NONE, CNT_CLR, CNT_ALLOC, CNT_FREE
    } t_cnt_op;

    typedef struct packed {
        logic              in_load;
        logic              cfg_load;
        t_rd_sel           rd_sel;
        logic              latch_cur;
        t_wr_op            wr_op;
        t_cnt_op           cnt_op;
        logic              fin;
        logic [STAT_W-1:0] fin_status;
        logic              fin_grant;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic act_free;
        logic in_null;
        logic in_bad;
        logic fit;
        logic link_zero;
        logic hit;
        logic split;
        logic cur_used;
        logic cur_zero;
        logic cnext_zero;
        logic m_used;
        logic out_free;
    } t_sts;

endpackage

>>> sv/ffpa_ctrl.sv
// Sequencer for allocate and free operations over the header chain.
module ffpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  ffpa_pkg::t_sts i_sts,
    output ffpa_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DECODE, S_A_WALK, S_A_SPLIT_CHK, S_A_SPLIT_CUR,
        S_A_FIX, S_A_FIN, S_F_WALK, S_F_HIT, S_F_BACK_CHK, S_F_BACK_FIX,
        S_F_FWD, S_F_FWD_CHK, S_F_FWD_FIX, S_DONE
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;

    always_comb begin
        o_cmd            = '0;
        o_cmd.rd_sel     = ffpa_pkg::RD_NONE;
        o_cmd.wr_op      = ffpa_pkg::WR_NONE;
        o_cmd.cnt_op     = ffpa_pkg::CNT_NONE;
        o_cmd.fin_status = ffpa_pkg::ST_OK;
        n_state          = r_state;
        case (r_state)
            S_INIT: begin
                o_cmd.wr_op  = ffpa_pkg::WR_INIT;
                o_cmd.cnt_op = ffpa_pkg::CNT_CLR;
                n_state      = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_valid) begin
                    o_cmd.cfg_load = 1'b1;
                    n_state        = S_INIT;
                end else if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.act_free) begin
                    o_cmd.rd_sel = ffpa_pkg::RD_ZERO;
                    n_state      = S_A_WALK;
                end else if (i_sts.in_null) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_DONE;
                end else if (i_sts.in_bad) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ffpa_pkg::ST_UNKNOWN;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_sel = ffpa_pkg::RD_ZERO;
                    n_state      = S_F_WALK;
                end
            end
            S_A_WALK: begin
                if (i_sts.fit) begin
                    o_cmd.latch_cur = 1'b1;
                    n_state         = S_A_SPLIT_CHK;
                end else if (i_sts.link_zero) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ffpa_pkg::ST_NOSPACE;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_sel = ffpa_pkg::RD_LINK;
                end
            end
            S_A_SPLIT_CHK: begin
                if (i_sts.split) begin
                    o_cmd.wr_op = ffpa_pkg::WR_SPLIT_NEW;
                    n_state     = S_A_SPLIT_CUR;
                end else begin
                    o_cmd.wr_op = ffpa_pkg::WR_SET_USED;
                    n_state     = S_A_FIN;
                end
            end
            S_A_SPLIT_CUR: begin
                o_cmd.wr_op = ffpa_pkg::WR_SPLIT_CUR;
                n_state     = i_sts.cnext_zero ? S_A_FIN : S_A_FIX;
            end
            S_A_FIX: begin
                o_cmd.wr_op = ffpa_pkg::WR_FIX_PREV_NB;
                n_state     = S_A_FIN;
            end
            S_A_FIN: begin
                o_cmd.cnt_op    = ffpa_pkg::CNT_ALLOC;
                o_cmd.fin       = 1'b1;
                o_cmd.fin_grant = 1'b1;
                n_state         = S_DONE;
            end
            S_F_WALK: begin
                if (i_sts.hit) begin
                    o_cmd.latch_cur = 1'b1;
                    n_state         = S_F_HIT;
                end else if (i_sts.link_zero) begin
                    o_cmd.fin        = 1'b1;
                    o_cmd.fin_status = ffpa_pkg::ST_UNKNOWN;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_sel = ffpa_pkg::RD_LINK;
                end
            end
            S_F_HIT: begin
                if (!i_sts.cur_used) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.wr_op  = ffpa_pkg::WR_CLR_USED;
                    o_cmd.cnt_op = ffpa_pkg::CNT_FREE;
                    if (!i_sts.cur_zero) begin
                        o_cmd.rd_sel = ffpa_pkg::RD_PREV;
                        n_state      = S_F_BACK_CHK;
                    end else begin
                        n_state = S_F_FWD;
                    end
                end
            end
            S_F_BACK_CHK: begin
                if (!i_sts.m_used) begin
                    o_cmd.wr_op = ffpa_pkg::WR_MERGE_BACK;
                    n_state     = S_F_BACK_FIX;
                end else begin
                    n_state = S_F_FWD;
                end
            end
            S_F_BACK_FIX: begin
                if (!i_sts.cnext_zero) begin
                    o_cmd.wr_op = ffpa_pkg::WR_FIX_PREV_CUR;
                end
                n_state = S_F_FWD;
            end
            S_F_FWD: begin
                if (!i_sts.cnext_zero) begin
                    o_cmd.rd_sel = ffpa_pkg::RD_NEXT;
                    n_state      = S_F_FWD_CHK;
                end else begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_F_FWD_CHK: begin
                if (!i_sts.m_used) begin
                    o_cmd.wr_op = ffpa_pkg::WR_MERGE_FWD;
                    n_state     = S_F_FWD_FIX;
                end else begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_F_FWD_FIX: begin
                if (!i_sts.cnext_zero) begin
                    o_cmd.wr_op = ffpa_pkg::WR_FIX_PREV_CUR;
                end
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    a_in_to_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted item did not enter decode");

    a_cfg_to_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_state == S_INIT))
        else $error("config write did not re-initialize pool");

    a_no_dual_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cfg_valid && o_cfg_ready && i_in_valid && o_in_ready))
        else $error("config write and item accepted together");

    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_WALK && !i_sts.fit && !i_sts.link_zero)
        |=> (r_state == S_A_WALK))
        else $error("allocate walk left early");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a pending result");

endmodule

>>> sv/ffpa_dp.sv
// Header memories, walk registers, counters and result register.
module ffpa_dp #(
    parameter int MAX_POOL_BYTES = ffpa_pkg::MAX_POOL_BYTES_DEF,
    parameter int HEADER_BYTES   = ffpa_pkg::HEADER_BYTES_DEF,
    parameter int GRANULE_BYTES  = ffpa_pkg::GRANULE_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ffpa_pkg::t_cmd                    i_cmd,
    output ffpa_pkg::t_sts                    o_sts,
    input  logic [ffpa_pkg::S_DATA_W-1:0]     i_in_data,
    input  logic                              i_in_user,
    input  logic [ffpa_pkg::SIZE_W-1:0]       i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ffpa_pkg::M_DATA_W-1:0]     o_out_data
);

    localparam int DEPTH  = MAX_POOL_BYTES / GRANULE_BYTES;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int GSH    = $clog2(GRANULE_BYTES);
    localparam int REQ_W  = ffpa_pkg::SIZE_W + 1;
    localparam int SW     = ffpa_pkg::SIZE_W;

    logic [SW-1:0]    mem_size [DEPTH];
    logic             mem_used [DEPTH];
    logic [IDX_W-1:0] mem_prev [DEPTH];
    logic [IDX_W-1:0] mem_next [DEPTH];

    logic [SW-1:0]    r_pool;
    logic             r_act;
    logic             r_null, r_bad;
    logic [REQ_W-1:0] r_req;
    logic [IDX_W-1:0] r_target;
    logic [IDX_W-1:0] r_raddr;
    logic [SW-1:0]    r_rd_size;
    logic             r_rd_used;
    logic [IDX_W-1:0] r_rd_prev, r_rd_next;
    logic [IDX_W-1:0] r_cur, r_cnext, r_cprev;
    logic [SW-1:0]    r_csize;
    logic             r_cused;
    logic [ffpa_pkg::CNT_W-1:0]  r_cnt;
    logic [SW-1:0]               r_bytes;
    logic [ffpa_pkg::STAT_W-1:0] r_status, r_out_status;
    logic                        r_grant;
    logic [ffpa_pkg::OFF_W-1:0]  r_out_grant;
    logic [ffpa_pkg::CNT_W-1:0]  r_out_cnt;
    logic [SW-1:0]               r_out_bytes;
    logic                        r_out_valid;

    logic [SW-1:0]    in_req, in_off;
    logic [31:0]      off_rel;
    logic [REQ_W-1:0] n_req;
    logic [IDX_W-1:0] n_raddr;
    logic [IDX_W-1:0] nb;
    logic [SW-1:0]    head_size, merge_back_size, merge_fwd_size;
    logic [REQ_W-1:0] extra;
    logic             rd_en;
    logic [IDX_W-1:0] w_addr;
    logic [SW-1:0]    w_size;
    logic             w_used;
    logic [IDX_W-1:0] w_prev, w_next;
    logic             we_size, we_used, we_prev, we_next;

    assign in_req  = i_in_data[SW-1:0];
    assign in_off  = i_in_data[2*SW-1:SW];
    assign off_rel = 32'(in_off) - 32'(HEADER_BYTES);
    assign n_req   = (REQ_W'(in_req) + REQ_W'(GRANULE_BYTES - 1))
                     & ~REQ_W'(GRANULE_BYTES - 1);

    always_comb begin
        if (32'(r_pool) > 32'(MAX_POOL_BYTES)) begin
            head_size = SW'(MAX_POOL_BYTES - HEADER_BYTES);
        end else if (32'(r_pool) > 32'(HEADER_BYTES)) begin
            head_size = r_pool - SW'(HEADER_BYTES);
        end else begin
            head_size = '0;
        end
    end

    assign nb    = IDX_W'(32'(r_cur) + ((32'(HEADER_BYTES) + 32'(r_req)) >> GSH));
    assign extra = REQ_W'(r_csize) - r_req;
    assign merge_back_size = r_rd_size + r_csize + SW'(HEADER_BYTES);
    assign merge_fwd_size  = r_csize + r_rd_size + SW'(HEADER_BYTES);

    always_comb begin
        rd_en = 1'b1;
        case (i_cmd.rd_sel)
            ffpa_pkg::RD_ZERO: n_raddr = '0;
            ffpa_pkg::RD_LINK: n_raddr = r_rd_next;
            ffpa_pkg::RD_PREV: n_raddr = r_cprev;
            ffpa_pkg::RD_NEXT: n_raddr = r_cnext;
            default: begin
                n_raddr = r_raddr;
                rd_en   = 1'b0;
            end
        endcase
    end

    // Write port: one entry per cycle, per-field enables.
    always_comb begin
        w_addr  = r_cur;
        w_size  = r_csize;
        w_used  = ffpa_pkg::HDR_FREE;
        w_prev  = r_cur;
        w_next  = r_cnext;
        we_size = 1'b0;
        we_used = 1'b0;
        we_prev = 1'b0;
        we_next = 1'b0;
        case (i_cmd.wr_op)
            ffpa_pkg::WR_INIT: begin
                w_addr  = '0;
                w_size  = head_size;
                w_next  = '0;
                we_size = 1'b1;
                we_used = 1'b1;
                we_next = 1'b1;
            end
            ffpa_pkg::WR_SPLIT_NEW: begin
                w_addr  = nb;
                w_size  = SW'(extra - REQ_W'(HEADER_BYTES));
                w_prev  = r_cur;
                w_next  = r_cnext;
                we_size = 1'b1;
                we_used = 1'b1;
                we_prev = 1'b1;
                we_next = 1'b1;
            end
            ffpa_pkg::WR_SPLIT_CUR: begin
                w_size  = SW'(r_req);
                w_used  = ffpa_pkg::HDR_USED;
                w_next  = nb;
                we_size = 1'b1;
                we_used = 1'b1;
                we_next = 1'b1;
            end
            ffpa_pkg::WR_FIX_PREV_NB: begin
                w_addr  = r_cnext;
                w_prev  = nb;
                we_prev = 1'b1;
            end
            ffpa_pkg::WR_FIX_PREV_CUR: begin
                w_addr  = r_cnext;
                w_prev  = r_cur;
                we_prev = 1'b1;
            end
            ffpa_pkg::WR_SET_USED: begin
                w_used  = ffpa_pkg::HDR_USED;
                we_used = 1'b1;
            end
            ffpa_pkg::WR_CLR_USED: begin
                we_used = 1'b1;
            end
            ffpa_pkg::WR_MERGE_BACK: begin
                w_addr  = r_raddr;
                w_size  = merge_back_size;
                w_next  = r_cnext;
                we_size = 1'b1;
                we_next = 1'b1;
            end
            ffpa_pkg::WR_MERGE_FWD: begin
                w_size  = merge_fwd_size;
                w_next  = r_rd_next;
                we_size = 1'b1;
                we_next = 1'b1;
            end
            default: begin
                w_addr = r_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_size) mem_size[w_addr] <= w_size;
        if (we_used) mem_used[w_addr] <= w_used;
        if (we_prev) mem_prev[w_addr] <= w_prev;
        if (we_next) mem_next[w_addr] <= w_next;
        if (rd_en) begin
            r_rd_size <= mem_size[n_raddr];
            r_rd_used <= mem_used[n_raddr];
            r_rd_prev <= mem_prev[n_raddr];
            r_rd_next <= mem_next[n_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr <= n_raddr;
        if (i_cmd.in_load) begin
            r_act    <= i_in_user;
            r_req    <= n_req;
            r_null   <= (in_off == '0);
            r_bad    <= (32'(in_off) < 32'(HEADER_BYTES))
                        || (off_rel[GSH-1:0] != '0)
                        || ((off_rel >> GSH) >= 32'(DEPTH));
            r_target <= IDX_W'(off_rel >> GSH);
        end
        if (i_cmd.latch_cur) begin
            r_cur   <= r_raddr;
            r_csize <= r_rd_size;
            r_cused <= r_rd_used;
            r_cnext <= r_rd_next;
            r_cprev <= r_rd_prev;
        end else if (i_cmd.wr_op == ffpa_pkg::WR_SPLIT_CUR) begin
            r_csize <= SW'(r_req);
        end else if (i_cmd.wr_op == ffpa_pkg::WR_MERGE_BACK) begin
            r_cur   <= r_raddr;
            r_csize <= merge_back_size;
        end else if (i_cmd.wr_op == ffpa_pkg::WR_MERGE_FWD) begin
            r_csize <= merge_fwd_size;
            r_cnext <= r_rd_next;
        end
        if (i_cmd.fin) begin
            r_status <= i_cmd.fin_status;
            r_grant  <= i_cmd.fin_grant;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_grant  <= r_grant
                ? ffpa_pkg::OFF_W'((32'(r_cur) << GSH) + 32'(HEADER_BYTES)) : '0;
            r_out_cnt    <= r_cnt;
            r_out_bytes  <= r_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool      <= ffpa_pkg::POOL_RESET;
            r_cnt       <= '0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_load) begin
                r_pool <= i_cfg_data;
            end
            case (i_cmd.cnt_op)
                ffpa_pkg::CNT_CLR: begin
                    r_cnt   <= '0;
                    r_bytes <= '0;
                end
                ffpa_pkg::CNT_ALLOC: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_bytes <= r_bytes + r_csize;
                end
                ffpa_pkg::CNT_FREE: begin
                    r_cnt   <= r_cnt - 1'b1;
                    r_bytes <= r_bytes - r_csize;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.act_free   = r_act;
    assign o_sts.in_null    = r_null;
    assign o_sts.in_bad     = r_bad;
    assign o_sts.fit        = (r_rd_used == ffpa_pkg::HDR_FREE)
                              && (REQ_W'(r_rd_size) >= r_req);
    assign o_sts.link_zero  = (r_rd_next == '0);
    assign o_sts.hit        = (r_raddr == r_target);
    assign o_sts.split      = (extra > REQ_W'(HEADER_BYTES));
    assign o_sts.cur_used   = r_cused;
    assign o_sts.cur_zero   = (r_cur == '0);
    assign o_sts.cnext_zero = (r_cnext == '0);
    assign o_sts.m_used     = r_rd_used;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {5'd0, r_out_bytes, r_out_cnt, r_out_grant, r_out_status};

endmodule

>>> sv/first_fit_pool_allocator.sv
// Top level of the first-fit pool allocator: controller plus datapath.
// Throughput: one item at a time; the walk reads one header per cycle, and a result
// held at the output stalls the next item.
// Reset (synchronous, active low) sets the pool size to 16384 bytes, clears the
// counters and writes the head header before taking items.
module first_fit_pool_allocator #(
    parameter int MAX_POOL_BYTES = ffpa_pkg::MAX_POOL_BYTES_DEF,
    parameter int HEADER_BYTES   = ffpa_pkg::HEADER_BYTES_DEF,
    parameter int GRANULE_BYTES  = ffpa_pkg::GRANULE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0: request_bytes[14:0], payload_offset[29:15], zero fill.
    input  logic [ffpa_pkg::S_DATA_W-1:0] s_axis_tdata,
    // Fields: action[0] (0 allocate, 1 free).
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0: status[1:0], granted_offset[16:2], used_blocks[27:17],
    // used_bytes[42:28], zero fill.
    output logic [ffpa_pkg::M_DATA_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    // The pool_bytes register.
    input  logic [ffpa_pkg::SIZE_W-1:0]   i_cfg_data
);

    // The controller and datapath talk only through these two structs.
    ffpa_pkg::t_cmd cmd;
    ffpa_pkg::t_sts sts;

    ffpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the header memories, the result register and counters.
    ffpa_dp #(
        .MAX_POOL_BYTES (MAX_POOL_BYTES),
        .HEADER_BYTES   (HEADER_BYTES),
        .GRANULE_BYTES  (GRANULE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

>>> tb/sv/first_fit_pool_allocator_tb.sv
// Self-checking testbench for the first-fit pool allocator.
`timescale 1ns / 1ps

module first_fit_pool_allocator_tb;

    localparam int HDR       = ffpa_pkg::HEADER_BYTES_DEF;
    localparam int GRAN      = ffpa_pkg::GRANULE_BYTES_DEF;
    localparam int MAX_POOL  = ffpa_pkg::MAX_POOL_BYTES_DEF;
    localparam int DEPTH     = MAX_POOL / GRAN;
    localparam int STALL_LIMIT = 20000;

    // Work list entries: an item to send, a pool size write, a wait until the
    // block has drained, a change of idling mode, or a long receiver hold-off.
    typedef enum logic [2:0] {K_ITEM, K_CFG, K_DRAIN, K_PHASE, K_HOLD} t_op_kind;

    typedef struct {
        t_op_kind                   kind;
        logic                       action;
        logic [ffpa_pkg::OFF_W-1:0] req;
        logic [ffpa_pkg::OFF_W-1:0] off;
        logic                       pick_live;
        int                         value;
        int                         value2;
    } t_op;

    typedef struct {
        logic [ffpa_pkg::STAT_W-1:0] status;
        logic [ffpa_pkg::OFF_W-1:0]  granted;
        logic [ffpa_pkg::CNT_W-1:0]  blocks;
        logic [ffpa_pkg::SIZE_W-1:0] bytes;
    } t_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [ffpa_pkg::S_DATA_W-1:0] s_axis_tdata = '0;
    logic                          s_axis_tuser = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [ffpa_pkg::M_DATA_W-1:0] m_axis_tdata;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [ffpa_pkg::SIZE_W-1:0]   i_cfg_data = '0;

    first_fit_pool_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the header memory and the usage counters.
    int unsigned hdr_size [DEPTH];
    logic        hdr_used [DEPTH];
    int unsigned hdr_prev [DEPTH];
    int unsigned hdr_next [DEPTH];
    int unsigned used_count;
    int unsigned used_total;
    int unsigned pool_now = 16384;

    // Payload offsets of blocks the pool currently has handed out.
    int unsigned live_offsets [$];

    t_op     pending_ops [$];
    t_result expected_results [$];

    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_len = 0;
    int hold_seq = 0;

    // Rebuilds the pool as one free block after a size write.
    function automatic void pool_reinit(int unsigned value);
        int unsigned p;
        p = value & 32'h7FFF;
        if (p > MAX_POOL)
            p = MAX_POOL;
        for (int i = 0; i < DEPTH; i++) begin
            hdr_size[i] = 0;
            hdr_used[i] = ffpa_pkg::HDR_FREE;
            hdr_prev[i] = 0;
            hdr_next[i] = 0;
        end
        hdr_size[0] = (p > HDR) ? p - HDR : 0;
        used_count = 0;
        used_total = 0;
        live_offsets.delete();
    endfunction

    // First-fit search from the head; splits when the leftover exceeds a header.
    function automatic logic [ffpa_pkg::STAT_W-1:0] alloc_block(int unsigned req,
                                                      output int unsigned granted);
        int unsigned idx, size, extra, nb, nx, rounded;
        bit found;
        idx = 0;
        found = 0;
        granted = 0;
        rounded = ((req + GRAN - 1) / GRAN) * GRAN;
        for (int steps = 0; steps < DEPTH && idx < DEPTH; steps++) begin
            if (hdr_used[idx] == ffpa_pkg::HDR_FREE && hdr_size[idx] >= rounded) begin
                found = 1;
                break;
            end
            idx = hdr_next[idx];
            if (idx == 0)
                break;
        end
        if (!found)
            return ffpa_pkg::ST_NOSPACE;
        size = hdr_size[idx];
        extra = size - rounded;
        if (extra > HDR) begin
            nb = idx + (HDR + rounded) / GRAN;
            if (nb < DEPTH) begin
                nx = hdr_next[idx];
                hdr_size[nb] = extra - HDR;
                hdr_used[nb] = ffpa_pkg::HDR_FREE;
                hdr_next[nb] = nx;
                hdr_prev[nb] = idx;
                hdr_next[idx] = nb;
                if (nx != 0 && nx < DEPTH)
                    hdr_prev[nx] = nb;
                hdr_size[idx] = rounded;
            end
        end
        hdr_used[idx] = ffpa_pkg::HDR_USED;
        used_count++;
        used_total += hdr_size[idx];
        granted = idx * GRAN + HDR;
        return ffpa_pkg::ST_OK;
    endfunction

    // Frees a block found on the chain and merges it with free neighbors.
    function automatic logic [ffpa_pkg::STAT_W-1:0] release_block(int unsigned off,
                                                        output bit released);
        int unsigned target, idx, o, n;
        bit found;
        released = 0;
        if (off == 0)
            return ffpa_pkg::ST_OK;
        if (off < HDR || ((off - HDR) % GRAN) != 0)
            return ffpa_pkg::ST_UNKNOWN;
        target = (off - HDR) / GRAN;
        if (target >= DEPTH)
            return ffpa_pkg::ST_UNKNOWN;
        idx = 0;
        found = 0;
        for (int steps = 0; steps < DEPTH && idx < DEPTH; steps++) begin
            if (idx == target) begin
                found = 1;
                break;
            end
            idx = hdr_next[idx];
            if (idx == 0)
                break;
        end
        if (!found)
            return ffpa_pkg::ST_UNKNOWN;
        if (hdr_used[idx] == ffpa_pkg::HDR_FREE)
            return ffpa_pkg::ST_OK;
        released = 1;
        used_count--;
        used_total -= hdr_size[idx];
        hdr_used[idx] = ffpa_pkg::HDR_FREE;
        if (idx != 0) begin
            o = hdr_prev[idx];
            if (o < DEPTH && hdr_used[o] == ffpa_pkg::HDR_FREE) begin
                hdr_size[o] += hdr_size[idx] + HDR;
                hdr_next[o] = hdr_next[idx];
                n = hdr_next[o];
                if (n != 0 && n < DEPTH)
                    hdr_prev[n] = o;
                idx = o;
            end
        end
        o = hdr_next[idx];
        if (o != 0 && o < DEPTH && hdr_used[o] == ffpa_pkg::HDR_FREE) begin
            hdr_size[idx] += hdr_size[o] + HDR;
            hdr_next[idx] = hdr_next[o];
            n = hdr_next[idx];
            if (n != 0 && n < DEPTH)
                hdr_prev[n] = idx;
        end
        return ffpa_pkg::ST_OK;
    endfunction

    // Applies one accepted item to the shadow pool and queues its result.
    function automatic void predict_result(logic action, int unsigned req,
                                           int unsigned off);
        t_result r;
        int unsigned granted;
        bit released;
        granted = 0;
        if (action == 1'b0) begin
            r.status = alloc_block(req, granted);
            if (r.status == ffpa_pkg::ST_OK)
                live_offsets.push_back(granted);
        end else begin
            r.status = release_block(off, released);
            if (released) begin
                foreach (live_offsets[i])
                    if (live_offsets[i] == off) begin
                        live_offsets.delete(i);
                        break;
                    end
            end
        end
        r.granted = granted[ffpa_pkg::OFF_W-1:0];
        r.blocks  = used_count[ffpa_pkg::CNT_W-1:0];
        r.bytes   = used_total[ffpa_pkg::SIZE_W-1:0];
        expected_results.push_back(r);
    endfunction

    initial pool_reinit(16384);

    // Driver: takes the head of the work list and offers it on the item or the
    // configuration channel, predicting each item at the edge it is accepted.
    logic        sent_action;
    int unsigned sent_req, sent_off, sent_cfg;
    int          quiet_cycles = 0;

    always @(posedge i_clk) begin : driver
        logic nxt_valid, nxt_cfg;
        t_op op;
        int unsigned off;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            nxt_valid = s_axis_tvalid;
            nxt_cfg = i_cfg_valid;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_result(sent_action, sent_req, sent_off);
                nxt_valid = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                pool_reinit(sent_cfg);
                nxt_cfg = 1'b0;
            end
            if (expected_results.size() == 0 && !nxt_valid && !nxt_cfg)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!nxt_valid && !nxt_cfg && pending_ops.size() > 0) begin
                op = pending_ops[0];
                case (op.kind)
                    K_ITEM: begin
                        if ($urandom_range(99) >= idle_pct) begin
                            void'(pending_ops.pop_front());
                            off = op.off;
                            // A live pick is resolved now, so it sees every earlier item.
                            if (op.pick_live)
                                off = (live_offsets.size() > 0)
                                    ? live_offsets[$urandom_range(live_offsets.size() - 1)]
                                    : 0;
                            sent_action = op.action;
                            sent_req = op.req;
                            sent_off = off;
                            s_axis_tdata <= {2'b00, off[ffpa_pkg::OFF_W-1:0], op.req};
                            s_axis_tuser <= op.action;
                            nxt_valid = 1'b1;
                        end
                    end
                    K_CFG: begin
                        // Size writes go in only once the block has been quiet a while.
                        if (quiet_cycles >= 8) begin
                            void'(pending_ops.pop_front());
                            sent_cfg = op.value;
                            i_cfg_data <= op.value[ffpa_pkg::SIZE_W-1:0];
                            nxt_cfg = 1'b1;
                        end
                    end
                    K_DRAIN: begin
                        if (quiet_cycles >= 1)
                            void'(pending_ops.pop_front());
                    end
                    K_PHASE: begin
                        void'(pending_ops.pop_front());
                        idle_pct = op.value;
                        stall_pct = op.value2;
                    end
                    default: begin
                        void'(pending_ops.pop_front());
                        hold_len = op.value;
                        hold_seq++;
                    end
                endcase
            end
            s_axis_tvalid <= nxt_valid;
            i_cfg_valid <= nxt_cfg;
        end
    end

    // Monitor: checks each result against the oldest expectation and paces
    // tready, including the long hold-offs the driver requests.
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge i_clk) begin : monitor
        t_result exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no expectation waiting: %h", m_axis_tdata);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_axis_tdata[1:0] !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status,
                               m_axis_tdata[1:0]);
                        errors++;
                    end
                    if (m_axis_tdata[16:2] !== exp_r.granted) begin
                        $error("granted_offset: expected %0d, got %0d", exp_r.granted,
                               m_axis_tdata[16:2]);
                        errors++;
                    end
                    if (m_axis_tdata[27:17] !== exp_r.blocks) begin
                        $error("used_blocks: expected %0d, got %0d", exp_r.blocks,
                               m_axis_tdata[27:17]);
                        errors++;
                    end
                    if (m_axis_tdata[42:28] !== exp_r.bytes) begin
                        $error("used_bytes: expected %0d, got %0d", exp_r.bytes,
                               m_axis_tdata[42:28]);
                        errors++;
                    end
                end
            end
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: ends the run when nothing at all moves for too long.
    int idle_run = 0;

    always @(posedge i_clk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void add_item(logic action, int unsigned req, int unsigned off,
                                     logic pick_live);
        t_op op;
        op.kind = K_ITEM;
        op.action = action;
        op.req = req[ffpa_pkg::OFF_W-1:0];
        op.off = off[ffpa_pkg::OFF_W-1:0];
        op.pick_live = pick_live;
        op.value = 0;
        op.value2 = 0;
        pending_ops.push_back(op);
    endfunction

    function automatic void add_ctl(t_op_kind kind, int value, int value2);
        t_op op;
        op.kind = kind;
        op.action = 1'b0;
        op.req = '0;
        op.off = '0;
        op.pick_live = 1'b0;
        op.value = value;
        op.value2 = value2;
        pending_ops.push_back(op);
    endfunction

    // Well-formed traffic mostly: allocations of modest size and frees of live
    // blocks; a few percent are huge requests and arbitrary offsets.
    function automatic void add_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 52)
            add_item(1'b0, $urandom_range(120), $urandom_range(32767), 1'b0);
        else if (pick < 56)
            add_item(1'b0, $urandom_range(32767), $urandom_range(32767), 1'b0);
        else if (pick < 92)
            add_item(1'b1, $urandom_range(32767), 0, 1'b1);
        else if (pick < 96)
            add_item(1'b1, $urandom_range(32767), HDR + GRAN * $urandom_range(300), 1'b0);
        else
            add_item(1'b1, $urandom_range(32767), $urandom_range(32767), 1'b0);
    endfunction

    int pool_sizes [12] = '{16, 8, 0, 32767, 24, 64, 200, 17000, 1000, 4096, 16384, 520};
    int idle_modes [4]  = '{0, 54, 0, 29};
    int stall_modes [4] = '{0, 0, 54, 29};

    initial begin
        // Directed part on the reset pool: extremes, null, misaligned, out-of-range
        // and double frees, zero requests and coalescing of neighbors.
        add_ctl(K_PHASE, 0, 0);
        add_item(1'b0, 0, 0, 1'b0);
        add_item(1'b0, 1, 0, 1'b0);
        add_item(1'b0, 32767, 32767, 1'b0);
        add_item(1'b0, 16384, 0, 1'b0);
        add_item(1'b0, 40, 0, 1'b0);
        add_item(1'b1, 0, 0, 1'b0);
        add_item(1'b1, 0, 3, 1'b0);
        add_item(1'b1, 0, 8, 1'b0);
        add_item(1'b1, 0, 32760, 1'b0);
        add_item(1'b1, 0, 32767, 1'b0);
        add_item(1'b1, 0, 16, 1'b0);
        add_item(1'b1, 0, 16, 1'b0);
        add_item(1'b1, 0, 40, 1'b0);
        add_item(1'b1, 32767, 0, 1'b1);
        add_item(1'b0, 24, 0, 1'b0);
        add_item(1'b1, 0, 0, 1'b1);
        add_item(1'b0, 16300, 0, 1'b0);
        add_item(1'b1, 0, 0, 1'b1);
        add_item(1'b0, 16368, 0, 1'b0);

        // Random part in segments, each with its own pool size and idling mode.
        for (int seg = 0; seg < 12; seg++) begin
            add_ctl(K_CFG, (seg == 11) ? $urandom_range(16, 16384) : pool_sizes[seg], 0);
            add_ctl(K_PHASE, idle_modes[seg % 4], stall_modes[seg % 4]);
            if (seg >= 2 && seg != 11) begin
                add_item(1'b0, 0, 0, 1'b0);
                add_item(1'b0, 8, 0, 1'b0);
            end
            for (int n = 0; n < 46; n++) begin
                add_random_item();
                // Long receiver hold-off while the sender keeps offering items.
                if (seg == 6 && n == 5)
                    add_ctl(K_HOLD, 400, 0);
                // The sender pauses until every result has come back.
                if (seg == 7 && n == 20)
                    add_ctl(K_DRAIN, 0, 0);
            end
        end
        add_ctl(K_CFG, 16384, 0);
        add_ctl(K_PHASE, 0, 0);
        for (int n = 0; n < 10; n++)
            add_random_item();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_axis_tvalid || i_cfg_valid
                || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
